// File: design/arb_pkg.sv
// Shared constants, state codes and operand selects for the arcball rotation unit.
package arb_pkg;

  localparam int REG_W          = 13;
  localparam int OUT_W          = 16;
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int NORM_SHIFT     = 20;
  localparam int SQRT_W         = 62;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [5:0] {
    S_IDLE, S_DIM, S_MA, S_MB, S_SAA, S_SBB, S_SDD, S_TEST, S_NORM,
    S_DX, S_DXW, S_DY, S_DYW,
    S_ISQ1, S_ISQ2, S_ISQ3, S_OSQ1, S_OSQ2, S_OSQ3, S_SQ, S_SQW, S_MAPPED,
    S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8, S_C9, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    M_NONE, M_DIM, M_A, M_B, M_AA, M_BB, M_DD, M_VXX, M_VYY, M_MAA, M_MBB,
    M_SY_EZ, M_SZ_EY, M_SZ_EX, M_SX_EZ, M_SX_EY, M_SY_EX, M_SX_EX, M_SY_EY, M_SZ_EZ
  } msel_t;

  typedef struct packed {
    msel_t msel;
    logic  div_go;
    logic  sqrt_go;
  } ctrl_t;

endpackage

// File: design/arb_mul.sv
// Shared signed multiplier with a registered product.
module arb_mul #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   op_a,
  input  logic signed [W-1:0]   op_b,
  output logic signed [2*W-1:0] prod
);

  logic signed [2*W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

// File: design/arb_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module arb_div #(
  parameter int NW = 45,
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW:0]     rem_r;
  logic [DW-1:0]   den_r;
  logic [NW-1:0]   q_r;
  logic [DW:0]     rem_sh;
  logic            ge;
  logic [DW:0]     rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[DW-1:0], q_r[NW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      q_r   <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: design/arb_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
module arb_sqrt #(
  parameter int IW = 62
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [IW-1:0]   radicand,
  output logic            done,
  output logic [IW/2-1:0] root
);

  localparam int RTW  = IW / 2;
  localparam int CNTW = $clog2(RTW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [IW-1:0]   val_r;
  logic [RTW:0]    rem_r;
  logic [RTW-1:0]  root_r;
  logic [RTW+2:0]  rem_sh;
  logic [RTW+2:0]  trial;
  logic            ge;
  logic [RTW+2:0]  rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, val_r[IW-1:IW-2]};
    trial   = (RTW+3)'({root_r, 2'b01});
    ge      = rem_sh >= trial;
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(RTW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= val_r << 2;
      rem_r  <= rem_nxt[RTW:0];
      root_r <= {root_r[RTW-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: design/arcball_rotation_unit.sv
// Arcball rotation unit: pointer position to sphere vector to rotation quaternion.
// Usage:
//   Input channel (in_valid/in_stall) carries a command, x_pos and y_pos. A start
//   transaction stores the sphere vector and gives no result; a move transaction
//   gives one output transaction with the quaternion from the stored vector.
//   Configuration (cfg_we/cfg_index/cfg_data) sets screen width and height; write
//   it only while the unit is idle.
//   One transaction is in work at a time; in_stall is high from acceptance until
//   the result is placed in the output register, or for a start until the vector
//   is stored. At the default fraction width each transaction makes two passes
//   through the 45-step divider and one through the 31-step square root, with up to
//   6 normalize shifts for points off the disc, besides its products on the shared
//   multiplier.
//   Each divider pass takes FRAC_BITS+31 steps and the root 31 steps.
//   The result waits in the output register while out_stall is high; a new input
//   transaction is taken meanwhile, and its result holds until the slot frees.
//   Synchronous reset sets width 640, height 480, clears the stored start vector
//   and drops any pending transaction.
module arcball_rotation_unit #(
  parameter int COORD_BITS = arb_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = arb_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [arb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arb_pkg::REG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [COORD_BITS-1:0]          in_x_pos,
  input  logic [COORD_BITS-1:0]          in_y_pos,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [arb_pkg::OUT_W-1:0] out_quat_w,
  output logic signed [arb_pkg::OUT_W-1:0] out_quat_x,
  output logic signed [arb_pkg::OUT_W-1:0] out_quat_y,
  output logic signed [arb_pkg::OUT_W-1:0] out_quat_z
);

  localparam int RW   = arb_pkg::REG_W;
  localparam int VW   = FRAC_BITS + 2;
  localparam int AW   = COORD_BITS + RW + 2;
  localparam int MW0  = (AW > VW) ? AW : VW;
  localparam int MW   = (MW0 > 2 * RW + 1) ? MW0 : 2 * RW + 1;
  localparam int PW   = 2 * MW;
  localparam int ACCW = PW + 2;
  localparam int NS   = arb_pkg::NORM_SHIFT;
  localparam int SQW  = arb_pkg::SQRT_W;
  localparam int DW   = SQW / 2;
  localparam int NW   = FRAC_BITS + NS + NS / 2 + 1;
  localparam int OW   = arb_pkg::OUT_W;
  localparam int XW   = (VW > OW) ? VW : OW;

  localparam logic signed [VW-1:0]   ONE    = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [ACCW-1:0] ONE_SQ = ACCW'(1) << (2 * FRAC_BITS);
  localparam logic [ACCW-1:0]        HALF   = ACCW'(1) << (FRAC_BITS - 1);

  arb_pkg::state_t state_r, state_nxt;
  arb_pkg::ctrl_t  ctrl;

  logic [RW-1:0] width_r, height_r;
  logic [RW-1:0] w_eff, h_eff, wm, hm;

  logic                  cmd_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic [2*RW-1:0]       d_r;
  logic signed [AW-1:0]  a_r, b_r, xs, ys;
  logic [AW-1:0]         ma_r, mb_r;
  logic                  neg_a_r, neg_b_r, inside_r;
  logic [DW-1:0]         r_r;
  logic signed [ACCW-1:0] acc_r;
  logic signed [VW-1:0]  vx_r, vy_r, vz_r;
  logic signed [VW-1:0]  sx_r, sy_r, sz_r;
  logic signed [VW-1:0]  cx_r, cy_r, cz_r;
  logic signed [VW-1:0]  dw_r;
  logic                  out_valid_r;
  logic signed [OW-1:0]  qw_r, qx_r, qy_r, qz_r;

  logic signed [MW-1:0]  op_a, op_b;
  logic signed [PW-1:0]  prod;
  logic signed [ACCW-1:0] prod_x;
  logic                  in_disc, big, out_free;

  logic [NW-1:0]  div_num;
  logic [DW-1:0]  div_den;
  logic           div_done;
  logic [NW-1:0]  div_q;
  logic [SQW-1:0] sq_in;
  logic           sq_done;
  logic [DW-1:0]  sq_root;

  function automatic logic signed [VW-1:0] rnd_one(input logic signed [ACCW-1:0] v);
    logic [ACCW-1:0]      mag;
    logic [ACCW-1:0]      q;
    logic signed [VW-1:0] m;
    mag = v[ACCW-1] ? ACCW'(-v) : ACCW'(v);
    q   = (mag + HALF) >> FRAC_BITS;
    m   = (q > ACCW'(ONE)) ? ONE : VW'(q);
    return v[ACCW-1] ? -m : m;
  endfunction

  function automatic logic signed [VW-1:0] sat_q(input logic [NW-1:0] q, input logic neg);
    logic signed [VW-1:0] m;
    m = (q > NW'(ONE)) ? ONE : VW'(q);
    return neg ? -m : m;
  endfunction

  function automatic logic signed [OW-1:0] to_out(input logic signed [VW-1:0] v);
    logic signed [XW-1:0] t;
    t = XW'(v);
    return t[OW-1:0];
  endfunction

  always_comb begin
    w_eff = (width_r < 13'd2) ? 13'd2 : width_r;
    h_eff = (height_r < 13'd2) ? 13'd2 : height_r;
    wm    = w_eff - 13'd1;
    hm    = h_eff - 13'd1;
    xs    = $signed(AW'({x_r, 1'b0})) - $signed(AW'(wm));
    ys    = $signed(AW'(hm)) - $signed(AW'({y_r, 1'b0}));
    prod_x   = ACCW'(prod);
    in_disc  = acc_r <= prod_x;
    big      = (|ma_r[AW-1:NS]) || (|mb_r[AW-1:NS]);
    out_free = !out_valid_r || !out_stall;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= arb_pkg::WIDTH_RESET;
      height_r <= arb_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arb_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_data;
        arb_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      arb_pkg::S_IDLE:   if (in_valid) state_nxt = arb_pkg::S_DIM;
      arb_pkg::S_DIM:    state_nxt = arb_pkg::S_MA;
      arb_pkg::S_MA:     state_nxt = arb_pkg::S_MB;
      arb_pkg::S_MB:     state_nxt = arb_pkg::S_SAA;
      arb_pkg::S_SAA:    state_nxt = arb_pkg::S_SBB;
      arb_pkg::S_SBB:    state_nxt = arb_pkg::S_SDD;
      arb_pkg::S_SDD:    state_nxt = arb_pkg::S_TEST;
      arb_pkg::S_TEST:   state_nxt = in_disc ? arb_pkg::S_DX : arb_pkg::S_NORM;
      arb_pkg::S_NORM:   if (!big) state_nxt = arb_pkg::S_OSQ1;
      arb_pkg::S_DX:     state_nxt = arb_pkg::S_DXW;
      arb_pkg::S_DXW:    if (div_done) state_nxt = arb_pkg::S_DY;
      arb_pkg::S_DY:     state_nxt = arb_pkg::S_DYW;
      arb_pkg::S_DYW: begin
        if (div_done) state_nxt = inside_r ? arb_pkg::S_ISQ1 : arb_pkg::S_MAPPED;
      end
      arb_pkg::S_ISQ1:   state_nxt = arb_pkg::S_ISQ2;
      arb_pkg::S_ISQ2:   state_nxt = arb_pkg::S_ISQ3;
      arb_pkg::S_ISQ3:   state_nxt = arb_pkg::S_SQ;
      arb_pkg::S_OSQ1:   state_nxt = arb_pkg::S_OSQ2;
      arb_pkg::S_OSQ2:   state_nxt = arb_pkg::S_OSQ3;
      arb_pkg::S_OSQ3:   state_nxt = arb_pkg::S_SQ;
      arb_pkg::S_SQ:     state_nxt = arb_pkg::S_SQW;
      arb_pkg::S_SQW: begin
        if (sq_done) begin
          if (inside_r || sq_root == '0) state_nxt = arb_pkg::S_MAPPED;
          else state_nxt = arb_pkg::S_DX;
        end
      end
      arb_pkg::S_MAPPED: state_nxt = cmd_r ? arb_pkg::S_C0 : arb_pkg::S_IDLE;
      arb_pkg::S_C0:     state_nxt = arb_pkg::S_C1;
      arb_pkg::S_C1:     state_nxt = arb_pkg::S_C2;
      arb_pkg::S_C2:     state_nxt = arb_pkg::S_C3;
      arb_pkg::S_C3:     state_nxt = arb_pkg::S_C4;
      arb_pkg::S_C4:     state_nxt = arb_pkg::S_C5;
      arb_pkg::S_C5:     state_nxt = arb_pkg::S_C6;
      arb_pkg::S_C6:     state_nxt = arb_pkg::S_C7;
      arb_pkg::S_C7:     state_nxt = arb_pkg::S_C8;
      arb_pkg::S_C8:     state_nxt = arb_pkg::S_C9;
      arb_pkg::S_C9:     state_nxt = arb_pkg::S_OUT;
      arb_pkg::S_OUT:    if (out_free) state_nxt = arb_pkg::S_IDLE;
      default:           state_nxt = arb_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl.msel    = arb_pkg::M_NONE;
    ctrl.div_go  = 1'b0;
    ctrl.sqrt_go = 1'b0;
    unique case (state_r)
      arb_pkg::S_DIM:  ctrl.msel = arb_pkg::M_DIM;
      arb_pkg::S_MA:   ctrl.msel = arb_pkg::M_A;
      arb_pkg::S_MB:   ctrl.msel = arb_pkg::M_B;
      arb_pkg::S_SAA:  ctrl.msel = arb_pkg::M_AA;
      arb_pkg::S_SBB:  ctrl.msel = arb_pkg::M_BB;
      arb_pkg::S_SDD:  ctrl.msel = arb_pkg::M_DD;
      arb_pkg::S_ISQ1: ctrl.msel = arb_pkg::M_VXX;
      arb_pkg::S_ISQ2: ctrl.msel = arb_pkg::M_VYY;
      arb_pkg::S_OSQ1: ctrl.msel = arb_pkg::M_MAA;
      arb_pkg::S_OSQ2: ctrl.msel = arb_pkg::M_MBB;
      arb_pkg::S_C0:   ctrl.msel = arb_pkg::M_SY_EZ;
      arb_pkg::S_C1:   ctrl.msel = arb_pkg::M_SZ_EY;
      arb_pkg::S_C2:   ctrl.msel = arb_pkg::M_SZ_EX;
      arb_pkg::S_C3:   ctrl.msel = arb_pkg::M_SX_EZ;
      arb_pkg::S_C4:   ctrl.msel = arb_pkg::M_SX_EY;
      arb_pkg::S_C5:   ctrl.msel = arb_pkg::M_SY_EX;
      arb_pkg::S_C6:   ctrl.msel = arb_pkg::M_SX_EX;
      arb_pkg::S_C7:   ctrl.msel = arb_pkg::M_SY_EY;
      arb_pkg::S_C8:   ctrl.msel = arb_pkg::M_SZ_EZ;
      arb_pkg::S_DX:   ctrl.div_go = 1'b1;
      arb_pkg::S_DY:   ctrl.div_go = 1'b1;
      arb_pkg::S_SQ:   ctrl.sqrt_go = 1'b1;
      default: ;
    endcase
  end

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctrl.msel)
      arb_pkg::M_DIM: begin
        op_a = MW'($signed({1'b0, wm}));
        op_b = MW'($signed({1'b0, hm}));
      end
      arb_pkg::M_A: begin
        op_a = MW'(xs);
        op_b = MW'($signed({1'b0, hm}));
      end
      arb_pkg::M_B: begin
        op_a = MW'(ys);
        op_b = MW'($signed({1'b0, wm}));
      end
      arb_pkg::M_AA: begin
        op_a = MW'(a_r);
        op_b = MW'(a_r);
      end
      arb_pkg::M_BB: begin
        op_a = MW'(b_r);
        op_b = MW'(b_r);
      end
      arb_pkg::M_DD: begin
        op_a = MW'($signed({1'b0, d_r}));
        op_b = MW'($signed({1'b0, d_r}));
      end
      arb_pkg::M_VXX: begin
        op_a = MW'(vx_r);
        op_b = MW'(vx_r);
      end
      arb_pkg::M_VYY: begin
        op_a = MW'(vy_r);
        op_b = MW'(vy_r);
      end
      arb_pkg::M_MAA: begin
        op_a = MW'($signed({1'b0, ma_r}));
        op_b = MW'($signed({1'b0, ma_r}));
      end
      arb_pkg::M_MBB: begin
        op_a = MW'($signed({1'b0, mb_r}));
        op_b = MW'($signed({1'b0, mb_r}));
      end
      arb_pkg::M_SY_EZ: begin
        op_a = MW'(sy_r);
        op_b = MW'(vz_r);
      end
      arb_pkg::M_SZ_EY: begin
        op_a = MW'(sz_r);
        op_b = MW'(vy_r);
      end
      arb_pkg::M_SZ_EX: begin
        op_a = MW'(sz_r);
        op_b = MW'(vx_r);
      end
      arb_pkg::M_SX_EZ: begin
        op_a = MW'(sx_r);
        op_b = MW'(vz_r);
      end
      arb_pkg::M_SX_EY: begin
        op_a = MW'(sx_r);
        op_b = MW'(vy_r);
      end
      arb_pkg::M_SY_EX: begin
        op_a = MW'(sy_r);
        op_b = MW'(vx_r);
      end
      arb_pkg::M_SX_EX: begin
        op_a = MW'(sx_r);
        op_b = MW'(vx_r);
      end
      arb_pkg::M_SY_EY: begin
        op_a = MW'(sy_r);
        op_b = MW'(vy_r);
      end
      arb_pkg::M_SZ_EZ: begin
        op_a = MW'(sz_r);
        op_b = MW'(vz_r);
      end
      default: ;
    endcase
  end

  // divider and root operands
  always_comb begin
    if (inside_r) begin
      div_num = ((state_r == arb_pkg::S_DY) ? (NW'(mb_r) << FRAC_BITS)
                                            : (NW'(ma_r) << FRAC_BITS)) + NW'(d_r >> 1);
      div_den = DW'(d_r);
    end else begin
      div_num = ((state_r == arb_pkg::S_DY) ? (NW'(mb_r[NS-1:0]) << (FRAC_BITS + NS / 2))
                                            : (NW'(ma_r[NS-1:0]) << (FRAC_BITS + NS / 2)))
                + NW'(r_r >> 1);
      div_den = r_r;
    end
    if (inside_r) sq_in = (acc_r > 0) ? acc_r[SQW-1:0] : '0;
    else sq_in = SQW'(acc_r[SQW-NS-1:0]) << NS;
  end

  arb_mul #(.W(MW)) u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  arb_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctrl.div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  arb_sqrt #(.IW(SQW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.sqrt_go),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      sx_r        <= '0;
      sy_r        <= '0;
      sz_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == arb_pkg::S_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == arb_pkg::S_MAPPED && !cmd_r) begin
        sx_r <= vx_r;
        sy_r <= vy_r;
        sz_r <= vz_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      arb_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_r <= in_command;
          x_r   <= in_x_pos;
          y_r   <= in_y_pos;
        end
      end
      arb_pkg::S_MA:   d_r <= prod[2*RW-1:0];
      arb_pkg::S_MB:   a_r <= prod[AW-1:0];
      arb_pkg::S_SAA:  b_r <= prod[AW-1:0];
      arb_pkg::S_SBB:  acc_r <= prod_x;
      arb_pkg::S_SDD:  acc_r <= acc_r + prod_x;
      arb_pkg::S_TEST: begin
        inside_r <= in_disc;
        neg_a_r  <= a_r[AW-1];
        neg_b_r  <= b_r[AW-1];
        ma_r     <= a_r[AW-1] ? AW'(-a_r) : AW'(a_r);
        mb_r     <= b_r[AW-1] ? AW'(-b_r) : AW'(b_r);
      end
      arb_pkg::S_NORM: begin
        if (big) begin
          ma_r <= ma_r >> 1;
          mb_r <= mb_r >> 1;
        end
      end
      arb_pkg::S_DXW:  if (div_done) vx_r <= sat_q(div_q, neg_a_r);
      arb_pkg::S_DYW: begin
        if (div_done) begin
          vy_r <= sat_q(div_q, neg_b_r);
          if (!inside_r) vz_r <= '0;
        end
      end
      arb_pkg::S_ISQ2: acc_r <= ONE_SQ - prod_x;
      arb_pkg::S_ISQ3: acc_r <= acc_r - prod_x;
      arb_pkg::S_OSQ2: acc_r <= prod_x;
      arb_pkg::S_OSQ3: acc_r <= acc_r + prod_x;
      arb_pkg::S_SQW: begin
        if (sq_done) begin
          if (inside_r) begin
            vz_r <= VW'(sq_root);
          end else begin
            r_r <= sq_root;
            if (sq_root == '0) begin
              vx_r <= '0;
              vy_r <= '0;
              vz_r <= '0;
            end
          end
        end
      end
      arb_pkg::S_C1:   acc_r <= prod_x;
      arb_pkg::S_C2:   cx_r <= rnd_one(acc_r - prod_x);
      arb_pkg::S_C3:   acc_r <= prod_x;
      arb_pkg::S_C4:   cy_r <= rnd_one(acc_r - prod_x);
      arb_pkg::S_C5:   acc_r <= prod_x;
      arb_pkg::S_C6:   cz_r <= rnd_one(acc_r - prod_x);
      arb_pkg::S_C7:   acc_r <= prod_x;
      arb_pkg::S_C8:   acc_r <= acc_r + prod_x;
      arb_pkg::S_C9:   dw_r <= rnd_one(acc_r + prod_x);
      arb_pkg::S_OUT: begin
        if (out_free) begin
          qw_r <= (cx_r == '0 && cy_r == '0 && cz_r == '0) ? to_out(ONE) : to_out(dw_r);
          qx_r <= to_out(cx_r);
          qy_r <= to_out(cy_r);
          qz_r <= to_out(cz_r);
        end
      end
      default: ;
    endcase
  end

  assign in_stall   = state_r != arb_pkg::S_IDLE;
  assign out_valid  = out_valid_r;
  assign out_quat_w = qw_r;
  assign out_quat_x = qx_r;
  assign out_quat_y = qy_r;
  assign out_quat_z = qz_r;

  a_vec_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == arb_pkg::S_MAPPED |-> (vx_r <= ONE && vx_r >= -ONE &&
                                      vy_r <= ONE && vy_r >= -ONE &&
                                      vz_r <= ONE && vz_r >= 0))
    else $error("sphere vector out of range");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == arb_pkg::S_DXW || state_r == arb_pkg::S_DYW))
    else $error("divider finished outside a wait state");

  a_sqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == arb_pkg::S_SQW)
    else $error("root finished outside its wait state");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == arb_pkg::S_OUT)
    else $error("result raised without a finished move");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the arcball rotation unit: predicted quaternions vs. the unit.
module testbench;

  localparam int CMD_START = 0;
  localparam int CMD_MOVE  = 1;
  localparam longint ONE_Q = 64'sd1 << 14;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;

  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [arb_pkg::CFG_IDX_W-1:0] cfg_index = arb_pkg::REG_SCREEN_WIDTH;
  logic [arb_pkg::REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic [11:0] in_x_pos = '0;
  logic [11:0] in_y_pos = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;

  arcball_rotation_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_x_pos(in_x_pos), .in_y_pos(in_y_pos), .out_valid(out_valid), .out_stall(out_stall),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z)
  );

  int unsigned view_w = arb_pkg::WIDTH_RESET;
  int unsigned view_h = arb_pkg::HEIGHT_RESET;
  longint anchor[3] = '{0, 0, 0};
  quat_t expected_quats[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  initial forever #2 clk = ~clk;

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > ONE_Q) return ONE_Q;
    if (v < -ONE_Q) return -ONE_Q;
    return v;
  endfunction

  task automatic sphere_point(input int px, input int py, output longint v[3]);
    longint wm, hm, a, b, d, ma, mb, r, vx, vy, rest;
    wm = ((view_w < 2) ? 2 : view_w) - 1;
    hm = ((view_h < 2) ? 2 : view_h) - 1;
    a = (2 * longint'(px) - wm) * hm;
    b = (hm - 2 * longint'(py)) * wm;
    d = wm * hm;
    if (a * a + b * b <= d * d) begin
      vx = clamp_one(round_div(a * ONE_Q, d));
      vy = clamp_one(round_div(b * ONE_Q, d));
      rest = ONE_Q * ONE_Q - vx * vx - vy * vy;
      v[0] = vx;
      v[1] = vy;
      v[2] = (rest > 0) ? floor_sqrt(rest) : 0;
    end else begin
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      while (ma >= (64'sd1 << 20) || mb >= (64'sd1 << 20)) begin
        ma >>>= 1;
        mb >>>= 1;
      end
      r = floor_sqrt((ma * ma + mb * mb) << 20);
      if (r == 0) begin
        v[0] = 0;
        v[1] = 0;
      end else begin
        vx = clamp_one(round_div(ma * (ONE_Q << 10), r));
        vy = clamp_one(round_div(mb * (ONE_Q << 10), r));
        v[0] = (a < 0) ? -vx : vx;
        v[1] = (b < 0) ? -vy : vy;
      end
      v[2] = 0;
    end
  endtask

  task automatic predict_rotation(input bit cmd, input int px, input int py);
    longint e[3];
    longint cx, cy, cz, dw;
    quat_t q;
    sphere_point(px, py, e);
    if (cmd == CMD_START) begin
      anchor = e;
    end else begin
      cx = clamp_one(round_div(anchor[1] * e[2] - anchor[2] * e[1], ONE_Q));
      cy = clamp_one(round_div(anchor[2] * e[0] - anchor[0] * e[2], ONE_Q));
      cz = clamp_one(round_div(anchor[0] * e[1] - anchor[1] * e[0], ONE_Q));
      dw = clamp_one(round_div(anchor[0] * e[0] + anchor[1] * e[1] + anchor[2] * e[2], ONE_Q));
      if (cx == 0 && cy == 0 && cz == 0) dw = ONE_Q;
      q.w = dw[15:0];
      q.x = cx[15:0];
      q.y = cy[15:0];
      q.z = cz[15:0];
      expected_quats.push_back(q);
    end
  endtask

  // receiver stall pattern and result check
  always @(posedge clk) begin
    quat_t q;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_quats.size() == 0) begin
        $error("unexpected result w=%0d x=%0d y=%0d z=%0d",
               out_quat_w, out_quat_x, out_quat_y, out_quat_z);
        errors++;
      end else begin
        q = expected_quats.pop_front();
        if (out_quat_w !== q.w) begin
          $error("quat_w expected %0d actual %0d", q.w, out_quat_w); errors++;
        end
        if (out_quat_x !== q.x) begin
          $error("quat_x expected %0d actual %0d", q.x, out_quat_x); errors++;
        end
        if (out_quat_y !== q.y) begin
          $error("quat_y expected %0d actual %0d", q.y, out_quat_y); errors++;
        end
        if (out_quat_z !== q.z) begin
          $error("quat_z expected %0d actual %0d", q.z, out_quat_z); errors++;
        end
      end
    end
    case ($urandom_range(3))
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(9) < 7);
      default: out_stall <= ($urandom_range(9) < 2);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_event(input bit cmd, input int px, input int py);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(8, 1);
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_x_pos <= px[11:0];
    in_y_pos <= py[11:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_rotation(cmd, px, py);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_viewport(input int unsigned w, input int unsigned h);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= arb_pkg::REG_SCREEN_WIDTH;
    cfg_data <= w[arb_pkg::REG_W-1:0];
    @(posedge clk);
    cfg_index <= arb_pkg::REG_SCREEN_HEIGHT;
    cfg_data <= h[arb_pkg::REG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    view_w = w[arb_pkg::REG_W-1:0];
    view_h = h[arb_pkg::REG_W-1:0];
  endtask

  task automatic test_directed();
    send_event(CMD_MOVE, 100, 100);
    send_event(CMD_START, 320, 240);
    send_event(CMD_MOVE, 320, 240);
    send_event(CMD_MOVE, 0, 0);
    send_event(CMD_MOVE, 639, 479);
    send_event(CMD_START, 0, 479);
    send_event(CMD_MOVE, 4095, 4095);
    send_event(CMD_MOVE, 4095, 0);
    send_event(CMD_START, 2730, 1365);
    send_event(CMD_MOVE, 1365, 2730);
    send_event(CMD_MOVE, 0, 4095);
  endtask

  task automatic test_viewport_extremes();
    set_viewport(2, 2);
    send_event(CMD_START, 0, 0);
    send_event(CMD_MOVE, 1, 1);
    send_event(CMD_MOVE, 4095, 0);
    set_viewport(0, 1);
    send_event(CMD_START, 1, 0);
    send_event(CMD_MOVE, 0, 1);
    set_viewport(4096, 4096);
    send_event(CMD_START, 2048, 2047);
    send_event(CMD_MOVE, 0, 4095);
    send_event(CMD_MOVE, 4095, 2048);
    set_viewport(8191, 3);
    send_event(CMD_START, 4095, 1);
    send_event(CMD_MOVE, 100, 2);
  endtask

  task automatic random_drags(input int count);
    int n, px, py;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) == 0) begin
        px = $urandom_range(4095);
        py = $urandom_range(4095);
      end else begin
        px = $urandom_range(((view_w < 2) ? 2 : view_w) - 1);
        py = $urandom_range(((view_h < 2) ? 2 : view_h) - 1);
      end
      send_event((n % 6 == 0 || $urandom_range(9) == 0) ? CMD_START : CMD_MOVE, px, py);
      n++;
    end
  endtask

  task automatic test_random();
    set_viewport(640, 480);
    random_drags(500);
    set_viewport($urandom_range(4096, 2), $urandom_range(4096, 2));
    random_drags(400);
    set_viewport($urandom_range(64, 2), $urandom_range(64, 2));
    random_drags(300);
    set_viewport(4096, 2);
    random_drags(300);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_viewport_extremes();
    test_random();
    drain();
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

// File: arcball_rotation_unit.f
design/arb_pkg.sv
design/arb_mul.sv
design/arb_div.sv
design/arb_sqrt.sv
design/arcball_rotation_unit.sv
tb/sv/testbench.sv
